### hdl/jbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jbd_pkg
// Shared types, format codes and the opcode format table of the bytecode
// instruction decoder.
// ----------------------------------------------------------------------------
package jbd_pkg;

    // Format codes reported with every decoded instruction.
    localparam logic [3:0] KIND_NONE      = 4'd0;
    localparam logic [3:0] KIND_BYTE      = 4'd1;
    localparam logic [3:0] KIND_INDEX16   = 4'd2;
    localparam logic [3:0] KIND_BRANCH16  = 4'd3;
    localparam logic [3:0] KIND_IINC      = 4'd4;
    localparam logic [3:0] KIND_MULTIANEW = 4'd5;
    localparam logic [3:0] KIND_INDY      = 4'd6;
    localparam logic [3:0] KIND_IFACE     = 4'd7;
    localparam logic [3:0] KIND_BRANCH32  = 4'd8;
    localparam logic [3:0] KIND_SWHEAD    = 4'd9;
    localparam logic [3:0] KIND_SWENTRY   = 4'd10;
    localparam logic [3:0] KIND_UNSUP     = 4'd11;

    // Width of the offset carried in a record; holds any supported offset width.
    localparam int REC_OFFS_W = 32;

    // Number of records the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 4;

    // Parser phases of the front end.
    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_OPERANDS,
        PH_PAD,
        PH_DEFAULT,
        PH_LOW,
        PH_HIGH,
        PH_ENTRY
    } phase_t;

    // One parsed instruction on its way from the front to the back end.
    // w is the last assembled word, p and q are held switch values.
    typedef struct packed {
        logic [3:0]            kind;
        logic [7:0]            opcode;
        logic [REC_OFFS_W-1:0] offs;
        logic [31:0]           w;
        logic [31:0]           p;
        logic [31:0]           q;
    } rec_t;

    // Queue status seen by the top level and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Operand format of each opcode byte.
    function automatic logic [3:0] classify(input logic [7:0] op);
        logic [3:0] k;
        case (op) inside
            8'h10, 8'h12, [8'h15:8'h19], [8'h36:8'h3a], 8'ha9, 8'hbc:
                k = KIND_BYTE;
            8'h11, 8'h13, 8'h14, [8'hb2:8'hb8], 8'hbb, 8'hbd, 8'hc0, 8'hc1:
                k = KIND_INDEX16;
            [8'h99:8'ha8], 8'hc6, 8'hc7:
                k = KIND_BRANCH16;
            8'h84:
                k = KIND_IINC;
            8'hc5:
                k = KIND_MULTIANEW;
            8'hba:
                k = KIND_INDY;
            8'hb9:
                k = KIND_IFACE;
            8'hc8, 8'hc9:
                k = KIND_BRANCH32;
            8'haa:
                k = KIND_SWHEAD;
            8'hab, 8'hc4, [8'hcb:8'hfd]:
                k = KIND_UNSUP;
            default:
                k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Number of operand bytes that follow the opcode for a format.
    function automatic logic [2:0] operand_len(input logic [3:0] kind);
        logic [2:0] n;
        case (kind)
            KIND_BYTE:                               n = 3'd1;
            KIND_INDEX16, KIND_BRANCH16, KIND_IINC:  n = 3'd2;
            KIND_MULTIANEW:                          n = 3'd3;
            default:                                 n = 3'd4;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

### hdl/jbd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jbd_front
// Byte parser: tracks the code offset, classifies opcodes, gathers big-endian
// operands and walks tableswitch padding, header and jump entries. Writes one
// record into the queue for every finished instruction or switch entry.
// ----------------------------------------------------------------------------
module jbd_front #(
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   code_byte,
    input  wire logic         first_of_method,
    output jbd_pkg::rec_t     rec,
    output logic              rec_valid
);
    import jbd_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [2:0]              bytes_left_reg, bytes_left_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic [7:0]              held_op_reg, held_op_next;
    logic [OFFSET_WIDTH-1:0] held_off_reg, held_off_next;
    logic [31:0]             word_reg, word_next;
    logic [31:0]             dflt_reg, dflt_next;
    logic [31:0]             low_reg, low_next;
    logic [31:0]             case_reg, case_next;
    logic [31:0]             high_reg, high_next;

    phase_t                  phase_cur;
    logic [2:0]              bytes_cur;
    logic [OFFSET_WIDTH-1:0] off;
    logic [31:0]             word_g;
    logic [2:0]              bytes_dec;
    logic                    done;
    logic                    pad_done;
    logic [3:0]              op_kind;

    // State registers advance once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPCODE;
            bytes_left_reg <= '0;
            offset_reg     <= '0;
            held_op_reg    <= '0;
            held_off_reg   <= '0;
            word_reg       <= '0;
            dflt_reg       <= '0;
            low_reg        <= '0;
            case_reg       <= '0;
            high_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            offset_reg     <= offset_next;
            held_op_reg    <= held_op_next;
            held_off_reg   <= held_off_next;
            word_reg       <= word_next;
            dflt_reg       <= dflt_next;
            low_reg        <= low_next;
            case_reg       <= case_next;
            high_reg       <= high_next;
        end
    end

    // A new method restarts the offset and drops any partial instruction.
    always_comb
    begin
        phase_cur = first_of_method ? PH_OPCODE : phase_reg;
        bytes_cur = first_of_method ? 3'd0 : bytes_left_reg;
        off       = first_of_method ? '0 : offset_reg;
        word_g    = {word_reg[23:0], code_byte};
        done      = (bytes_cur <= 3'd1);
        bytes_dec = (bytes_cur == 3'd0) ? 3'd0 : bytes_cur - 3'd1;
        pad_done  = &off[1:0];
        op_kind   = classify(code_byte);
    end

    // Next state and the record written for a finished instruction.
    always_comb
    begin
        phase_next      = phase_cur;
        bytes_left_next = bytes_cur;
        offset_next     = off + 1'b1;
        held_op_next    = held_op_reg;
        held_off_next   = held_off_reg;
        word_next       = word_reg;
        dflt_next       = dflt_reg;
        low_next        = low_reg;
        case_next       = case_reg;
        high_next       = high_reg;
        rec_valid       = 1'b0;
        rec.kind        = KIND_NONE;
        rec.opcode      = held_op_reg;
        rec.offs        = REC_OFFS_W'(held_off_reg);
        rec.w           = '0;
        rec.p           = '0;
        rec.q           = '0;

        case (phase_cur)
            PH_OPCODE:
            begin
                held_op_next  = code_byte;
                held_off_next = off;
                if (op_kind == KIND_NONE || op_kind == KIND_UNSUP)
                begin
                    rec_valid  = 1'b1;
                    rec.kind   = op_kind;
                    rec.opcode = code_byte;
                    rec.offs   = REC_OFFS_W'(off);
                end
                else if (op_kind == KIND_SWHEAD)
                begin
                    if (pad_done)
                    begin
                        phase_next      = PH_DEFAULT;
                        bytes_left_next = 3'd4;
                        word_next       = '0;
                    end
                    else
                    begin
                        phase_next = PH_PAD;
                    end
                end
                else
                begin
                    phase_next      = PH_OPERANDS;
                    bytes_left_next = operand_len(op_kind);
                    word_next       = '0;
                end
            end

            PH_OPERANDS:
            begin
                word_next       = word_g;
                bytes_left_next = bytes_dec;
                if (done)
                begin
                    rec_valid  = 1'b1;
                    rec.kind   = classify(held_op_reg);
                    rec.w      = word_g;
                    phase_next = PH_OPCODE;
                end
            end

            PH_PAD:
            begin
                if (pad_done)
                begin
                    phase_next      = PH_DEFAULT;
                    bytes_left_next = 3'd4;
                    word_next       = '0;
                end
            end

            PH_DEFAULT:
            begin
                word_next       = word_g;
                bytes_left_next = bytes_dec;
                if (done)
                begin
                    dflt_next       = word_g;
                    phase_next      = PH_LOW;
                    bytes_left_next = 3'd4;
                    word_next       = '0;
                end
            end

            PH_LOW:
            begin
                word_next       = word_g;
                bytes_left_next = bytes_dec;
                if (done)
                begin
                    low_next        = word_g;
                    case_next       = word_g;
                    phase_next      = PH_HIGH;
                    bytes_left_next = 3'd4;
                    word_next       = '0;
                end
            end

            PH_HIGH:
            begin
                word_next       = word_g;
                bytes_left_next = bytes_dec;
                if (done)
                begin
                    high_next = word_g;
                    rec_valid = 1'b1;
                    rec.kind  = KIND_SWHEAD;
                    rec.p     = dflt_reg;
                    rec.q     = low_reg;
                    rec.w     = word_g;
                    // An empty range ends the switch after the header.
                    if ($signed(low_reg) > $signed(word_g))
                    begin
                        phase_next = PH_OPCODE;
                    end
                    else
                    begin
                        phase_next      = PH_ENTRY;
                        bytes_left_next = 3'd4;
                        word_next       = '0;
                    end
                end
            end

            PH_ENTRY:
            begin
                word_next       = word_g;
                bytes_left_next = bytes_dec;
                if (done)
                begin
                    rec_valid = 1'b1;
                    rec.kind  = KIND_SWENTRY;
                    rec.p     = case_reg;
                    rec.w     = word_g;
                    if (case_reg == high_reg)
                    begin
                        phase_next = PH_OPCODE;
                    end
                    else
                    begin
                        case_next       = case_reg + 32'd1;
                        bytes_left_next = 3'd4;
                        word_next       = '0;
                    end
                end
            end

            default:
            begin
                phase_next = PH_OPCODE;
            end
        endcase
    end

    // Gathering phases always have at least one byte still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_OPERANDS || phase_reg == PH_DEFAULT || phase_reg == PH_LOW ||
         phase_reg == PH_HIGH || phase_reg == PH_ENTRY)
        |-> (bytes_left_reg >= 3'd1 && bytes_left_reg <= 3'd4))
        else $error("jbd_front: gathering phase with no bytes left");

    // A word that starts a method leaves the offset at one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && first_of_method |=> offset_reg == OFFSET_WIDTH'(1))
        else $error("jbd_front: offset did not restart on a new method");

    // Jump entries never run past the high value.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ENTRY |-> $signed(case_reg) <= $signed(high_reg))
        else $error("jbd_front: switch case value beyond high");

endmodule
`default_nettype wire

### hdl/jbd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jbd_queue
// Short record queue that decouples the byte parser from the result stage.
// ----------------------------------------------------------------------------
module jbd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_rec,
    input  wire jbd_pkg::rec_t  push_data,
    input  wire logic           pop_rec,
    output jbd_pkg::rec_t       head,
    output jbd_pkg::q_stat_t    stat
);
    import jbd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rec_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Guard the pointers against a push into a full or a pop from an empty queue.
    always_comb
    begin
        stat.full   = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.empty  = (count_reg == '0);
        head        = entry_reg[rd_ptr_reg];
        do_push     = push_rec && !(count_reg == CNT_W'(QUEUE_DEPTH));
        do_pop      = pop_rec && !(count_reg == '0);
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointer and fill count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("jbd_queue: fill count overflow");

    // The parser never offers a record while the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        push_rec |-> !stat.full)
        else $error("jbd_queue: push into a full queue");

    // A push alone grows the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("jbd_queue: count did not follow a push");

endmodule
`default_nettype wire

### hdl/jbd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jbd_back
// Result stage: takes the oldest record from the queue, forms branch and
// switch targets, splits packed operands and holds the result word in an
// output register until it is popped.
// ----------------------------------------------------------------------------
module jbd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire jbd_pkg::rec_t      head,
    input  wire jbd_pkg::q_stat_t   stat,
    output logic                    take_rec,
    input  wire logic               pop,
    output logic                    empty,
    output logic [15:0]             instr_offset,
    output logic [7:0]              opcode_value,
    output logic [3:0]              format_kind,
    output logic signed [31:0]      operand_a,
    output logic signed [31:0]      operand_b,
    output logic signed [31:0]      operand_c
);
    import jbd_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] offset_reg;
    logic [7:0]  opcode_reg;
    logic [3:0]  kind_reg;
    logic [31:0] a_reg, b_reg, c_reg;
    logic [31:0] a_fmt, b_fmt, c_fmt;
    logic        pop_ok;

    // Load a new word from the queue whenever it is not empty and the output register is free or being popped.
    always_comb
    begin
        pop_ok         = pop && out_valid_reg;
        take_rec       = !stat.empty && (!out_valid_reg || pop_ok);
        out_valid_next = take_rec ? 1'b1 : (pop_ok ? 1'b0 : out_valid_reg);
    end

    // Operand formatting per format code.
    always_comb
    begin
        a_fmt = '0;
        b_fmt = '0;
        c_fmt = '0;
        case (head.kind)
            KIND_BYTE, KIND_INDEX16:
            begin
                a_fmt = head.w;
            end
            KIND_BRANCH16:
            begin
                a_fmt = head.offs + {{16{head.w[15]}}, head.w[15:0]};
            end
            KIND_IINC, KIND_MULTIANEW:
            begin
                a_fmt = {8'd0, head.w[31:8]};
                b_fmt = {24'd0, head.w[7:0]};
            end
            KIND_INDY, KIND_IFACE:
            begin
                a_fmt = {16'd0, head.w[31:16]};
                b_fmt = {24'd0, head.w[15:8]};
                c_fmt = {24'd0, head.w[7:0]};
            end
            KIND_BRANCH32:
            begin
                a_fmt = head.offs + head.w;
            end
            KIND_SWHEAD:
            begin
                a_fmt = head.offs + head.p;
                b_fmt = head.q;
                c_fmt = head.w;
            end
            KIND_SWENTRY:
            begin
                a_fmt = head.p;
                b_fmt = head.w;
            end
            default:
            begin
                a_fmt = '0;
            end
        endcase
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (take_rec)
        begin
            offset_reg <= head.offs[15:0];
            opcode_reg <= head.opcode;
            kind_reg   <= head.kind;
            a_reg      <= a_fmt;
            b_reg      <= b_fmt;
            c_reg      <= c_fmt;
        end
    end

    assign empty        = !out_valid_reg;
    assign instr_offset = offset_reg;
    assign opcode_value = opcode_reg;
    assign format_kind  = kind_reg;
    assign operand_a    = a_reg;
    assign operand_b    = b_reg;
    assign operand_c    = c_reg;

endmodule
`default_nettype wire

### hdl/jvm_bytecode_instruction_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jvm_bytecode_instruction_decoder_unit
// Java bytecode decoder, one code byte per input word, one decoded
// instruction or tableswitch entry per result word.
// ----------------------------------------------------------------------------
// Usage:
// - Input side is a queue write port: a word (code_byte, first_of_method) is
//   taken at a rising edge with push high and full low. Mark the opcode byte
//   at offset 0 of each method with first_of_method.
// - Result side is a queue read port: while empty is low the oldest result
//   word is on the result ports; it is taken at an edge with pop high.
// - Throughput is one byte per cycle while full is low. The parser writes a record
//   into a four-entry queue in the cycle the last byte of an instruction is taken;
//   the result stage takes it from there once its output register is free or popped.
// - Branch targets and the switch default target are added in the result
//   stage, which holds one word in its output register.
// - When pop stays low, the output register and then the queue fill and full
//   rises; the parser then holds its state until space frees up.
// - Reset clears the code offset, the parser phase and all held values; the
//   queue and the output register come out of reset empty.
// ----------------------------------------------------------------------------
module jvm_bytecode_instruction_decoder_unit #(
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         code_byte,
    input  wire logic               first_of_method,
    output logic                    empty,
    input  wire logic               pop,
    output logic [15:0]             instr_offset,
    output logic [7:0]              opcode_value,
    output logic [3:0]              format_kind,
    output logic signed [31:0]      operand_a,
    output logic signed [31:0]      operand_b,
    output logic signed [31:0]      operand_c
);
    import jbd_pkg::*;

    rec_t    rec;
    rec_t    head;
    q_stat_t stat;
    logic    rec_valid;
    logic    accept;
    logic    take_rec;

    assign full   = stat.full;
    assign accept = push && !stat.full;

    // Front end: byte parser.
    jbd_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .code_byte       (code_byte),
        .first_of_method (first_of_method),
        .rec             (rec),
        .rec_valid       (rec_valid)
    );

    // Record queue between the two halves.
    jbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_rec  (accept && rec_valid),
        .push_data (rec),
        .pop_rec   (take_rec),
        .head      (head),
        .stat      (stat)
    );

    // Back end: result formatting and output register.
    jbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .stat         (stat),
        .take_rec     (take_rec),
        .pop          (pop),
        .empty        (empty),
        .instr_offset (instr_offset),
        .opcode_value (opcode_value),
        .format_kind  (format_kind),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .operand_c    (operand_c)
    );

endmodule
`default_nettype wire
